### sv/fpr_pkg.sv
// Shared types, register codes and fixed-point helpers for the flagged point rotator.
package fpr_pkg;

    typedef logic signed [31:0] q30_t;
    typedef logic signed [31:0] q16_t;
    typedef logic signed [32:0] diff_t;
    typedef logic signed [63:0] acc_t;
    typedef q30_t [8:0]          mtx_t;

    typedef enum logic [2:0] {
        REG_COS,
        REG_SIN,
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z,
        REG_ORG_X,
        REG_ORG_Y,
        REG_ORG_Z
    } cfg_reg_t;

    localparam int   CFG_IDX_W = 4;
    localparam int   MTX_LAT   = 4;
    localparam q30_t ONE_Q30   = 32'sh4000_0000;
    localparam acc_t HALF_Q30  = 64'sd536870912;
    localparam acc_t ONE_Q30_W = 64'sd1073741824;
    localparam acc_t Q16_MAX   = 64'sd2147483647;
    localparam acc_t Q16_MIN   = -64'sd2147483648;

    function automatic q30_t clamp_q30(input acc_t v);
        q30_t r;
        if (v > ONE_Q30_W) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30_W) begin
            r = -ONE_Q30;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic q30_t to_q30(input acc_t v);
        acc_t t;
        t = (v + HALF_Q30) >>> 30;
        return clamp_q30(t);
    endfunction

    function automatic q16_t sat_q16(input acc_t v);
        q16_t r;
        if (v > Q16_MAX) begin
            r = 32'sh7fff_ffff;
        end else if (v < Q16_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/fpr_matrix.sv
// Four-stage pipeline that turns the half-angle and axis registers into the rotation matrix.
module fpr_matrix (
    input  logic               aclk,
    input  fpr_pkg::q30_t      half_cos,
    input  fpr_pkg::q30_t      half_sin,
    input  fpr_pkg::q30_t      axis [3],
    output fpr_pkg::mtx_t      mtx
);
    import fpr_pkg::*;

    acc_t  pe_reg  [3];
    q30_t  e0a_reg;
    q30_t  e_reg   [4];
    acc_t  p_reg   [10];
    mtx_t  mtx_reg;

    // quaternion vector part: axis * sin
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            pe_reg[k] <= acc_t'(axis[k]) * acc_t'(half_sin);
        end
        e0a_reg <= clamp_q30(acc_t'(half_cos));
    end

    always_ff @(posedge aclk) begin
        e_reg[0] <= e0a_reg;
        for (int k = 0; k < 3; k++) begin
            e_reg[k+1] <= to_q30(pe_reg[k]);
        end
    end

    // ten pairwise products, Q2.60
    always_ff @(posedge aclk) begin
        p_reg[0] <= acc_t'(e_reg[0]) * acc_t'(e_reg[0]);
        p_reg[1] <= acc_t'(e_reg[1]) * acc_t'(e_reg[1]);
        p_reg[2] <= acc_t'(e_reg[2]) * acc_t'(e_reg[2]);
        p_reg[3] <= acc_t'(e_reg[3]) * acc_t'(e_reg[3]);
        p_reg[4] <= acc_t'(e_reg[0]) * acc_t'(e_reg[1]);
        p_reg[5] <= acc_t'(e_reg[0]) * acc_t'(e_reg[2]);
        p_reg[6] <= acc_t'(e_reg[0]) * acc_t'(e_reg[3]);
        p_reg[7] <= acc_t'(e_reg[1]) * acc_t'(e_reg[2]);
        p_reg[8] <= acc_t'(e_reg[1]) * acc_t'(e_reg[3]);
        p_reg[9] <= acc_t'(e_reg[2]) * acc_t'(e_reg[3]);
    end

    always_ff @(posedge aclk) begin
        mtx_reg[0] <= to_q30(p_reg[0] + p_reg[1] - p_reg[2] - p_reg[3]);
        mtx_reg[4] <= to_q30(p_reg[0] - p_reg[1] + p_reg[2] - p_reg[3]);
        mtx_reg[8] <= to_q30(p_reg[0] - p_reg[1] - p_reg[2] + p_reg[3]);
        mtx_reg[1] <= to_q30((p_reg[7] - p_reg[6]) <<< 1);
        mtx_reg[2] <= to_q30((p_reg[8] + p_reg[5]) <<< 1);
        mtx_reg[5] <= to_q30((p_reg[9] - p_reg[4]) <<< 1);
        mtx_reg[3] <= to_q30((p_reg[7] + p_reg[6]) <<< 1);
        mtx_reg[6] <= to_q30((p_reg[8] - p_reg[5]) <<< 1);
        mtx_reg[7] <= to_q30((p_reg[9] + p_reg[4]) <<< 1);
    end

    assign mtx = mtx_reg;

endmodule

### sv/flagged_point_rotator_unit.sv
// Rotates Q15.16 points about a configured axis through a configured origin; one point per clock
// unless a low m_ready or a matrix refresh holds it (five register stages: input, origin subtract,
// nine matrix multiplies, row sum with rounding, origin add with saturation). Unflagged points
// pass unchanged. The rotation matrix comes from a separate four-stage pipeline fed by the
// registers; after reset and after every register write s_ready stays low while that pipeline
// refreshes. Register writes are taken at any time but belong between point sets.
module flagged_point_rotator_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [31:0]           s_pos_x,
    input  logic signed [31:0]           s_pos_y,
    input  logic signed [31:0]           s_pos_z,
    input  logic                         s_rotate_flag,
    input  logic                         s_last_point,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_out_x,
    output logic signed [31:0]           m_out_y,
    output logic signed [31:0]           m_out_z,
    output logic                         m_last_out
);
    import fpr_pkg::*;

    localparam int SETTLE_CYC = MTX_LAT - 2;
    localparam int SETTLE_W   = $clog2(SETTLE_CYC + 1);

    q30_t cos_reg;
    q30_t sin_reg;
    q30_t axis_reg [3];
    q16_t org_reg  [3];
    logic [SETTLE_W-1:0] settle_reg;
    mtx_t mtx;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic f1_reg, f2_reg, f3_reg, f4_reg;
    logic l1_reg, l2_reg, l3_reg, l4_reg, l5_reg;
    q16_t pos1_reg [3];
    q16_t pos2_reg [3];
    q16_t pos3_reg [3];
    q16_t pos4_reg [3];
    diff_t d2_reg  [3];
    logic signed [64:0] prod3_reg [9];
    acc_t sum4_reg [3];
    q16_t out_reg  [3];
    logic signed [64:0] sum_next [3];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= ONE_Q30;
            sin_reg    <= '0;
            axis_reg   <= '{'0, '0, ONE_Q30};
            org_reg    <= '{'0, '0, '0};
            settle_reg <= SETTLE_W'(SETTLE_CYC);
        end else begin
            if (cfg_valid && cfg_ready) begin
                settle_reg <= SETTLE_W'(SETTLE_CYC);
                if (cfg_index[CFG_IDX_W-1:3] == '0) begin
                    unique case (cfg_reg_t'(cfg_index[2:0]))
                        REG_COS:    cos_reg     <= cfg_data;
                        REG_SIN:    sin_reg     <= cfg_data;
                        REG_AXIS_X: axis_reg[0] <= cfg_data;
                        REG_AXIS_Y: axis_reg[1] <= cfg_data;
                        REG_AXIS_Z: axis_reg[2] <= cfg_data;
                        REG_ORG_X:  org_reg[0]  <= cfg_data;
                        REG_ORG_Y:  org_reg[1]  <= cfg_data;
                        REG_ORG_Z:  org_reg[2]  <= cfg_data;
                        default:    cos_reg     <= cos_reg;
                    endcase
                end
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - 1'b1;
            end
        end
    end

    assign cfg_ready = 1'b1;

    fpr_matrix u_matrix (
        .aclk     (aclk),
        .half_cos (cos_reg),
        .half_sin (sin_reg),
        .axis     (axis_reg),
        .mtx      (mtx)
    );

    // stall chain
    assign rdy5    = !v5_reg || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1 && (settle_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid && s_ready;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum_next[r] = (prod3_reg[3*r] >>> 2) + (prod3_reg[3*r+1] >>> 2)
                        + (prod3_reg[3*r+2] >>> 2) + 65'sd134217728;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            pos1_reg[0] <= s_pos_x;
            pos1_reg[1] <= s_pos_y;
            pos1_reg[2] <= s_pos_z;
            f1_reg      <= s_rotate_flag;
            l1_reg      <= s_last_point;
        end
        if (rdy2) begin
            for (int c = 0; c < 3; c++) begin
                d2_reg[c]   <= diff_t'(pos1_reg[c]) - diff_t'(org_reg[c]);
                pos2_reg[c] <= pos1_reg[c];
            end
            f2_reg <= f1_reg;
            l2_reg <= l1_reg;
        end
        if (rdy3) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod3_reg[3*r+c] <= 65'(mtx[3*r+c]) * 65'(d2_reg[c]);
                end
            end
            pos3_reg <= pos2_reg;
            f3_reg   <= f2_reg;
            l3_reg   <= l2_reg;
        end
        if (rdy4) begin
            for (int r = 0; r < 3; r++) begin
                sum4_reg[r] <= sum_next[r][63:0];
            end
            pos4_reg <= pos3_reg;
            f4_reg   <= f3_reg;
            l4_reg   <= l3_reg;
        end
        if (rdy5) begin
            for (int r = 0; r < 3; r++) begin
                if (f4_reg) begin
                    out_reg[r] <= sat_q16((sum4_reg[r] >>> 28) + acc_t'(org_reg[r]));
                end else begin
                    out_reg[r] <= pos4_reg[r];
                end
            end
            l5_reg <= l4_reg;
        end
    end

    assign m_valid    = v5_reg;
    assign m_out_x    = out_reg[0];
    assign m_out_y    = out_reg[1];
    assign m_out_z    = out_reg[2];
    assign m_last_out = l5_reg;

    a_cfg_holds_input : assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_ready)
        else $error("input taken right after a register write");

    a_accept_fills_s1 : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted beat lost at input stage");

    a_pass_through : assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && rdy5 && !f4_reg) |=> (m_out_x == $past(pos4_reg[0]) && m_valid))
        else $error("unflagged point altered");

    a_no_drop : assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !rdy5) |=> v4_reg)
        else $error("stalled beat dropped in row-sum stage");

endmodule
